[rtl/ccpp_pkg.sv]
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types and codes for the coin changer poll reply parser.
// ----------------------------------------------------------------------------
package ccpp_pkg;

    // default byte limit of one reply
    localparam int unsigned MAX_REPLY_BYTES_DEF = 16;

    // event codes
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_DISPENSE = 3'd1;
    localparam logic [2:0] EV_ACCEPTED = 3'd2;
    localparam logic [2:0] EV_REJECTED = 3'd3;
    localparam logic [2:0] EV_SLUG     = 3'd4;
    localparam logic [2:0] EV_STATUS   = 3'd5;
    localparam logic [2:0] EV_UNKNOWN  = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TUBE_SENSOR = 3'd1;
    localparam logic [2:0] ERR_UNPLUGGED   = 3'd2;
    localparam logic [2:0] ERR_TUBE_JAM    = 3'd3;
    localparam logic [2:0] ERR_ROM         = 3'd4;
    localparam logic [2:0] ERR_ROUTING     = 3'd5;
    localparam logic [2:0] ERR_COIN_JAM    = 3'd6;
    localparam logic [2:0] ERR_REMOVAL     = 3'd7;

    // status codes from the low five bits
    localparam logic [4:0] ST_ESCROW      = 5'd1;
    localparam logic [4:0] ST_PAYOUT_BUSY = 5'd2;
    localparam logic [4:0] ST_NO_CREDIT   = 5'd3;
    localparam logic [4:0] ST_TUBE_SENSOR = 5'd4;
    localparam logic [4:0] ST_DOUBLE_ARR  = 5'd5;
    localparam logic [4:0] ST_UNPLUGGED   = 5'd6;
    localparam logic [4:0] ST_TUBE_JAM    = 5'd7;
    localparam logic [4:0] ST_ROM         = 5'd8;
    localparam logic [4:0] ST_ROUTING     = 5'd9;
    localparam logic [4:0] ST_BUSY        = 5'd10;
    localparam logic [4:0] ST_RESET       = 5'd11;
    localparam logic [4:0] ST_COIN_JAM    = 5'd12;
    localparam logic [4:0] ST_REMOVAL     = 5'd13;

    // configuration register indexes
    localparam logic [1:0] CFG_COIN_SCALE = 2'd0;
    localparam logic [1:0] CFG_TABLE_LOW  = 2'd1;
    localparam logic [1:0] CFG_TABLE_HIGH = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [3:0]  coin_kind;
        logic [31:0] credit_total;
        logic [2:0]  error_code;
        logic        escrow_flag;
        logic        reset_seen;
        logic        changer_busy;
        logic        payout_active;
        logic        reply_done;
    } out_word_t;

endpackage

[rtl/coin_changer_poll_parser_core.sv]
// ----------------------------------------------------------------------------
// coin_changer_poll_parser_core
// Classifies a coin changer's poll reply one byte per word and keeps the
// running credit, sticky error and escrow state and per-reply status flags.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready/in_data) takes one reply byte per word,
//   with last_byte marking the end of a reply
// - output channel (out_valid/out_ready/out_data) gives one result word per
//   input word, in order
// - configuration writes (cfg_wr_en/cfg_index/cfg_wr_data) set the coin scale
//   and the two halves of the credit table; indexes past the table are dropped
// - an accepted word is held in the input register, classified from there, and
//   its result is registered in the result register once the output is free
// - throughput is one word per cycle while the receiver does not stall, set by
//   the single classify stage and its 8x8 multiply with a saturating 32-bit add
// - when the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are full
// - reset clears the credit total, sticky flags, reply position and the
//   configuration registers; no clearing pass is needed
// ----------------------------------------------------------------------------
module coin_changer_poll_parser_core
    import ccpp_pkg::*;
#(
    parameter int unsigned MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wr_data
);

    localparam logic [4:0] POS_LIMIT = 5'(MAX_REPLY_BYTES);
    localparam logic [4:0] POS_MAX   = 5'd31;

    // configuration registers
    logic [7:0]  coin_scale_reg;
    logic [63:0] table_low_reg;
    logic [63:0] table_high_reg;

    // pipeline registers
    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;

    // parser state
    logic [4:0]  byte_pos_reg;
    logic        second_pending_reg;
    logic        skip_rest_reg;
    logic [31:0] credit_sum_reg;
    logic [2:0]  last_error_reg;
    logic        escrow_seen_reg;
    logic [2:0]  reply_flags_reg;

    logic [4:0]  byte_pos_next;
    logic        second_pending_next;
    logic        skip_rest_next;
    logic [31:0] credit_sum_next;
    logic [2:0]  last_error_next;
    logic        escrow_seen_next;
    logic [2:0]  reply_flags_next;
    out_word_t   out_word_next;

    logic        advance;
    logic [7:0]  rx;
    logic [3:0]  kind;
    logic [63:0] table_word;
    logic [7:0]  table_credit;
    logic [15:0] credit_amount;
    logic [32:0] credit_wide;
    logic [2:0]  ev;
    logic [3:0]  coin;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // credit lookup and scaled saturating add
    assign rx            = in_word_reg.rx_byte;
    assign kind          = rx[3:0];
    assign table_word    = kind[3] ? table_high_reg : table_low_reg;
    assign table_credit  = table_word[{kind[2:0], 3'b000} +: 8];
    assign credit_amount = {8'd0, table_credit} * {8'd0, coin_scale_reg};
    assign credit_wide   = {1'b0, credit_sum_reg} + {17'd0, credit_amount};

    // classify one byte
    always_comb
    begin
        second_pending_next = second_pending_reg;
        skip_rest_next      = skip_rest_reg;
        credit_sum_next     = credit_sum_reg;
        last_error_next     = last_error_reg;
        escrow_seen_next    = escrow_seen_reg;
        reply_flags_next    = reply_flags_reg;
        ev                  = EV_IGNORED;
        coin                = 4'd0;

        if (second_pending_reg)
        begin
            second_pending_next = 1'b0;
        end
        else if (!skip_rest_reg && (byte_pos_reg < POS_LIMIT))
        begin
            if (rx[7])
            begin
                ev                  = EV_DISPENSE;
                coin                = kind;
                second_pending_next = 1'b1;
            end
            else if (rx[6])
            begin
                coin                = kind;
                second_pending_next = 1'b1;
                if (!rx[5])
                begin
                    ev              = EV_ACCEPTED;
                    credit_sum_next = credit_wide[32] ? 32'hFFFF_FFFF : credit_wide[31:0];
                end
                else
                begin
                    ev = EV_REJECTED;
                end
            end
            else if (rx[5])
            begin
                ev = EV_SLUG;
            end
            else
            begin
                ev = EV_STATUS;
                case (rx[4:0])
                    ST_ESCROW:      escrow_seen_next    = 1'b1;
                    ST_PAYOUT_BUSY: reply_flags_next[2] = 1'b1;
                    ST_NO_CREDIT:   ;
                    ST_TUBE_SENSOR: last_error_next     = ERR_TUBE_SENSOR;
                    ST_DOUBLE_ARR:  ;
                    ST_UNPLUGGED:   last_error_next     = ERR_UNPLUGGED;
                    ST_TUBE_JAM:    last_error_next     = ERR_TUBE_JAM;
                    ST_ROM:         last_error_next     = ERR_ROM;
                    ST_ROUTING:     last_error_next     = ERR_ROUTING;
                    ST_BUSY:        reply_flags_next[1] = 1'b1;
                    ST_RESET:       reply_flags_next[0] = 1'b1;
                    ST_COIN_JAM:    last_error_next     = ERR_COIN_JAM;
                    ST_REMOVAL:     last_error_next     = ERR_REMOVAL;
                    default:
                    begin
                        ev             = EV_UNKNOWN;
                        skip_rest_next = 1'b1;
                    end
                endcase
            end
        end

        byte_pos_next = (byte_pos_reg < POS_MAX) ? byte_pos_reg + 5'd1 : byte_pos_reg;

        // result shows the flags before the end of reply clears them
        out_word_next.event_kind    = ev;
        out_word_next.coin_kind     = coin;
        out_word_next.credit_total  = credit_sum_next;
        out_word_next.error_code    = last_error_next;
        out_word_next.escrow_flag   = escrow_seen_next;
        out_word_next.reset_seen    = reply_flags_next[0];
        out_word_next.changer_busy  = reply_flags_next[1];
        out_word_next.payout_active = reply_flags_next[2];
        out_word_next.reply_done    = in_word_reg.last_byte;

        // end of reply
        if (in_word_reg.last_byte)
        begin
            byte_pos_next       = 5'd0;
            second_pending_next = 1'b0;
            skip_rest_next      = 1'b0;
            reply_flags_next    = 3'd0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_scale_reg <= 8'd0;
            table_low_reg  <= 64'd0;
            table_high_reg <= 64'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COIN_SCALE: coin_scale_reg <= cfg_wr_data[7:0];
                CFG_TABLE_LOW:  table_low_reg  <= cfg_wr_data;
                CFG_TABLE_HIGH: table_high_reg <= cfg_wr_data;
                default:        ;
            endcase
        end
    end

    // pipeline control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            byte_pos_reg       <= 5'd0;
            second_pending_reg <= 1'b0;
            skip_rest_reg      <= 1'b0;
            credit_sum_reg     <= 32'd0;
            last_error_reg     <= ERR_NONE;
            escrow_seen_reg    <= 1'b0;
            reply_flags_reg    <= 3'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                byte_pos_reg       <= byte_pos_next;
                second_pending_reg <= second_pending_next;
                skip_rest_reg      <= skip_rest_next;
                credit_sum_reg     <= credit_sum_next;
                last_error_reg     <= last_error_next;
                escrow_seen_reg    <= escrow_seen_next;
                reply_flags_reg    <= reply_flags_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the coin changer poll reply parser. A queue of
// reply bytes feeds a valid/ready driver, a predictor tracks the expected
// result word of each accepted byte, and a monitor compares every result
// word field by field. Directed replies come first, then random replies
// under several register settings, then a run of full-scale deposits that
// grows the credit total in large steps.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccpp_pkg::*;

    localparam logic [1:0]  CFG_SPARE     = 2'd3;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned CHUNK_BYTES   = 150;
    localparam int unsigned FILL_REPLIES  = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_COIN_SCALE;
    logic [63:0] cfg_wr_data = '0;

    // stimulus and expectation stores
    in_word_t    pending_words[$];
    out_word_t   expected_words[$];
    logic        in_fire = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // run bookkeeping
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned reply_count = 0;
    int unsigned setting_count = 0;

    // predictor copy of the registers
    logic [7:0]  scale_reg = '0;
    logic [63:0] credit_lo = '0;
    logic [63:0] credit_hi = '0;

    // predictor copy of the parser state
    logic [4:0]  byte_count = '0;
    logic        pair_pending = 1'b0;
    logic        skipping = 1'b0;
    logic [31:0] credit_acc = '0;
    logic [2:0]  err_sticky = ERR_NONE;
    logic        escrow_sticky = 1'b0;
    logic        flag_reset = 1'b0;
    logic        flag_busy = 1'b0;
    logic        flag_payout = 1'b0;

    coin_changer_poll_parser_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // classify one reply byte and advance the predicted parser state
    function automatic out_word_t parse_byte(in_word_t w);
        out_word_t    r;
        logic [127:0] credit_tbl;
        logic [7:0]   credit;
        logic [15:0]  product;
        logic [32:0]  sum;
        r = '0;
        r.event_kind = EV_IGNORED;
        credit_tbl = {credit_hi, credit_lo};
        if (pair_pending)
        begin
            // second byte of a two-byte event
            pair_pending = 1'b0;
        end
        else if (!skipping && byte_count < MAX_REPLY_BYTES_DEF)
        begin
            if (w.rx_byte[7])
            begin
                r.event_kind = EV_DISPENSE;
                r.coin_kind = w.rx_byte[3:0];
                pair_pending = 1'b1;
            end
            else if (w.rx_byte[6])
            begin
                r.coin_kind = w.rx_byte[3:0];
                pair_pending = 1'b1;
                if (w.rx_byte[5:4] < 2'd2)
                begin
                    // accepted coin: scaled table credit, saturating add
                    r.event_kind = EV_ACCEPTED;
                    credit = credit_tbl[int'(w.rx_byte[3:0]) * 8 +: 8];
                    product = 16'(credit) * 16'(scale_reg);
                    sum = {1'b0, credit_acc} + {17'd0, product};
                    credit_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                else
                begin
                    r.event_kind = EV_REJECTED;
                end
            end
            else if (w.rx_byte[5])
            begin
                r.event_kind = EV_SLUG;
            end
            else
            begin
                r.event_kind = EV_STATUS;
                case (w.rx_byte[4:0])
                    ST_ESCROW:      escrow_sticky = 1'b1;
                    ST_PAYOUT_BUSY: flag_payout = 1'b1;
                    ST_NO_CREDIT,
                    ST_DOUBLE_ARR:  ;
                    ST_TUBE_SENSOR: err_sticky = ERR_TUBE_SENSOR;
                    ST_UNPLUGGED:   err_sticky = ERR_UNPLUGGED;
                    ST_TUBE_JAM:    err_sticky = ERR_TUBE_JAM;
                    ST_ROM:         err_sticky = ERR_ROM;
                    ST_ROUTING:     err_sticky = ERR_ROUTING;
                    ST_BUSY:        flag_busy = 1'b1;
                    ST_RESET:       flag_reset = 1'b1;
                    ST_COIN_JAM:    err_sticky = ERR_COIN_JAM;
                    ST_REMOVAL:     err_sticky = ERR_REMOVAL;
                    default:
                    begin
                        // unknown status drops the rest of the reply
                        r.event_kind = EV_UNKNOWN;
                        skipping = 1'b1;
                    end
                endcase
            end
        end
        if (byte_count < 5'd31)
        begin
            byte_count = byte_count + 5'd1;
        end
        r.credit_total = credit_acc;
        r.error_code = err_sticky;
        r.escrow_flag = escrow_sticky;
        r.reset_seen = flag_reset;
        r.changer_busy = flag_busy;
        r.payout_active = flag_payout;
        r.reply_done = w.last_byte;
        // end of reply clears the per-reply state
        if (w.last_byte)
        begin
            byte_count = '0;
            pair_pending = 1'b0;
            skipping = 1'b0;
            flag_reset = 1'b0;
            flag_busy = 1'b0;
            flag_payout = 1'b0;
            reply_count++;
        end
        return r;
    endfunction

    task automatic push_word(logic [7:0] b, logic last);
        in_word_t w;
        w.rx_byte = b;
        w.last_byte = last;
        pending_words.push_back(w);
    endtask

    // one random reply, mostly well-formed events with some noise
    task automatic add_random_reply(inout int unsigned live);
        int unsigned len;
        int unsigned pos;
        int unsigned pick;
        logic [4:0]  code;
        logic [7:0]  b;
        pick = $urandom_range(99);
        len = (pick < 8) ? $urandom_range(24, 17) : $urandom_range(16, 1);
        pos = 0;
        while (pos < len)
        begin
            pick = $urandom_range(99);
            code = 5'($urandom_range(18, 0));
            if (pick < 20)
                b = {1'b1, 7'($urandom)};
            else if (pick < 45)
                b = {2'b01, 6'($urandom)};
            else if (pick < 53)
                b = {3'b001, 5'($urandom)};
            else if (pick < 86)
                b = {3'b000, 5'($urandom_range(ST_REMOVAL, ST_ESCROW))};
            else if (pick < 89)
                b = {3'b000, (code == 5'd0) ? code : code + ST_REMOVAL};
            else
                b = 8'($urandom);
            push_word(b, pos == len - 1);
            if (pos < MAX_REPLY_BYTES_DEF)
            begin
                live++;
            end
            pos++;
            // tube count byte of a two-byte event
            if ((b[7] || b[6]) && pos < len)
            begin
                push_word(8'($urandom), pos == len - 1);
                pos++;
            end
        end
    endtask

    // register write, one per cycle, model updated alongside
    task automatic write_reg(logic [1:0] index, logic [63:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wr_data <= data;
        case (index)
            CFG_COIN_SCALE: scale_reg = data[7:0];
            CFG_TABLE_LOW:  credit_lo = data;
            CFG_TABLE_HIGH: credit_hi = data;
            default:        ;
        endcase
    endtask

    task automatic write_settings(logic [7:0] scale, logic [63:0] lo, logic [63:0] hi);
        write_reg(CFG_COIN_SCALE, {$urandom, 24'($urandom), scale});
        write_reg(CFG_TABLE_LOW, lo);
        write_reg(CFG_TABLE_HIGH, hi);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    // sender holds off until every expected word has come back
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_words.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // accepted input word: predict its result
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            expected_words.push_back(parse_byte(in_data));
        end
    end

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t tb: mismatch on %s, expected %0h actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // output monitor
    always @(posedge clk)
    begin : monitor
        out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t tb: unexpected result word, expected none actual %0h",
                         $time, out_data);
                error_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                check_field("event_kind", 32'(exp_w.event_kind),
                            32'(out_data.event_kind));
                check_field("coin_kind", 32'(exp_w.coin_kind), 32'(out_data.coin_kind));
                check_field("credit_total", exp_w.credit_total, out_data.credit_total);
                check_field("error_code", 32'(exp_w.error_code),
                            32'(out_data.error_code));
                check_field("escrow_flag", 32'(exp_w.escrow_flag),
                            32'(out_data.escrow_flag));
                check_field("reset_seen", 32'(exp_w.reset_seen),
                            32'(out_data.reset_seen));
                check_field("changer_busy", 32'(exp_w.changer_busy),
                            32'(out_data.changer_busy));
                check_field("payout_active", 32'(exp_w.payout_active),
                            32'(out_data.payout_active));
                check_field("reply_done", 32'(exp_w.reply_done),
                            32'(out_data.reply_done));
            end
            result_count++;
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin : watchdog
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // sequencer
    initial
    begin : sequencer
        int unsigned live;
        int unsigned chunk;
        int unsigned st;
        int unsigned rep;
        int unsigned pair;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed replies
        send_idle_pct = 32;
        recv_idle_pct = 78;
        write_reg(CFG_SPARE, {$urandom, $urandom});
        write_settings(8'hFF, {$urandom, $urandom}, {8'hFF, 24'($urandom), $urandom});

        // deposit, every status code, then the byte limit
        push_word(8'h4F, 1'b0);
        push_word(8'hFF, 1'b0);
        for (st = ST_ESCROW; st <= ST_REMOVAL; st++)
        begin
            push_word({3'b000, 5'(st)}, 1'b0);
        end
        push_word(8'h8F, 1'b0);
        push_word(8'h55, 1'b0);
        push_word({3'b000, ST_ESCROW}, 1'b1);

        // a credited routing, both rejected routings, slug, unknown status
        push_word(8'h5A, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h63, 1'b0);
        push_word(8'h12, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h20, 1'b0);
        push_word(8'h1F, 1'b0);
        push_word({3'b000, ST_RESET}, 1'b1);

        // reply ends with a tube count still owed
        push_word(8'h87, 1'b1);
        push_word({3'b000, ST_RESET}, 1'b1);
        wait_idle();

        // random replies under changing settings and idle mixes
        for (chunk = 0; chunk < 6; chunk++)
        begin
            if (chunk == 2)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 32;
            end
            else if (chunk == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (chunk)
                0: write_settings(8'h00, {$urandom, $urandom}, {$urandom, $urandom});
                1: write_settings(8'hFF, '1, '1);
                2: write_settings(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
                3: write_settings(8'h01, '0, '0);
                4: write_settings(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
                default: write_settings(8'($urandom), '0, '1);
            endcase
            live = 0;
            while (live < CHUNK_BYTES)
            begin
                add_random_reply(live);
            end
            wait_idle();
        end

        // back-to-back deposits at full scale and full table credit
        write_settings(8'hFF, '1, '1);
        for (rep = 0; rep < FILL_REPLIES; rep++)
        begin
            for (pair = 0; pair < 8; pair++)
            begin
                push_word({3'b010, 1'($urandom), 4'($urandom)}, 1'b0);
                push_word(8'($urandom), pair == 7);
            end
        end
        wait_idle();

        if (expected_words.size() != 0)
        begin
            error_count++;
        end
        $display("tb: %0d result words checked over %0d replies and %0d register settings",
                 result_count, reply_count, setting_count);
        $display("tb: credit total finished at %0h, %0d mismatches", credit_acc, error_count);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
